>>> design/chained_hash_set_assert.svh
// Assertion macros shared by the chained hash set modules.
// Each expects clk and rst in scope.
`ifndef CHAINED_HASH_SET_ASSERT_SVH
`define CHAINED_HASH_SET_ASSERT_SVH

// Property must hold at every edge out of reset.
`define CHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition must never be seen out of reset.
`define CHS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

>>> design/chs_pkg.sv
package chs_pkg;

  localparam int BUCKETS      = 7;
  localparam int BUCKET_DEPTH = 8;
  localparam int KEY_BITS     = 32;

  localparam int SLOTS  = BUCKETS * BUCKET_DEPTH;
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int IDX_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // key residue is built one byte per cycle, most significant byte first
  localparam int HASH_CYCLES = (KEY_BITS + 7) / 8;
  localparam int HPAD_W      = HASH_CYCLES * 8;
  localparam int HCNT_W      = (HASH_CYCLES > 1) ? $clog2(HASH_CYCLES) : 1;

  typedef logic [1:0]          cmd_t;
  typedef logic [1:0]          status_t;
  typedef logic [KEY_BITS-1:0] key_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_FIND   = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_PRESENT   = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic ins_write;
    logic fill_inc;
    logic fill_dec;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic hash_last;
    logic hit;
    logic drained;
    logic full;
  } dp_stat_t;

  // Fold one byte into a running residue modulo BUCKETS, one bit a step.
  function automatic logic [BKT_W-1:0] mod_byte(logic [BKT_W-1:0] r, logic [7:0] b);
    logic [BKT_W:0] t;
    t = {1'b0, r};
    for (int i = 7; i >= 0; i--) begin
      t = {t[BKT_W-1:0], b[i]};
      if (t >= (BKT_W+1)'(BUCKETS)) begin
        t = t - (BKT_W+1)'(BUCKETS);
      end
    end
    return t[BKT_W-1:0];
  endfunction

endpackage

>>> design/chained_hash_set.sv
// Each accepted item goes through the key residue, built one byte per cycle, then a
// scan of its bucket, one slot per cycle, then one insert write or, on delete, one
// entry moved down per cycle, and finally the result state. One item at a time: the
// next item can be taken the cycle after the result is registered, while that result
// may still wait.
// Reset clears all bucket fill counts at once; slot contents are not cleared.
module chained_hash_set
  import chs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [1:0]  status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  chs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .command (command),
    .key     (key),
    .cmd     (cmd),
    .stat    (stat)
  );

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .status    (status),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> design/chs_datapath.sv
`include "chained_hash_set_assert.svh"

module chs_datapath
  import chs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           command,
  input  logic [31:0]          key,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  key_t                  key_r;
  cmd_t                  cmd_r;
  logic [HPAD_W-1:0]     hkey;
  logic [HCNT_W-1:0]     hcnt;
  logic [BKT_W-1:0]      bucket;
  logic [FILL_W-1:0]     idx;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;
  logic [FILL_W-1:0]     fill [BUCKETS];
  key_t                  mem [SLOTS];
  key_t                  rdata;

  logic [FILL_W-1:0]     fill_cur;
  logic                  more;
  logic                  step;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  key_t                  wr_data;
  logic [IDX_W-1:0]      shift_dst;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [BKT_W-1:0] b, logic [IDX_W-1:0] i);
    return ADDR_W'(ADDR_W'(b) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(i));
  endfunction

  assign fill_cur  = fill[bucket];
  assign more      = idx < fill_cur;
  assign step      = cmd.scan_step || cmd.shift_step;
  assign shift_dst = pend_idx - IDX_W'(1);

  assign stat.cmd       = cmd_r;
  assign stat.hash_last = hcnt == HCNT_W'(HASH_CYCLES - 1);
  assign stat.hit       = pend && (rdata == key_r);
  assign stat.drained   = !pend && !more;
  assign stat.full      = fill_cur == FILL_W'(BUCKET_DEPTH);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_addr(bucket, fill_cur[IDX_W-1:0]);
    wr_data = key_r;
    if (cmd.ins_write) begin
      wr_en = 1'b1;
    end else if (cmd.shift_step && pend) begin
      // move the entry just read down one place
      wr_en   = 1'b1;
      wr_addr = slot_addr(bucket, shift_dst);
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (step && more) begin
      rdata <= mem[slot_addr(bucket, idx[IDX_W-1:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket <= '0;
    end else if (cmd.load) begin
      key_r  <= key_t'(key);
      cmd_r  <= command;
      hkey   <= HPAD_W'(key_t'(key));
      bucket <= '0;
    end else if (cmd.hash_step) begin
      bucket <= mod_byte(bucket, hkey[HPAD_W-1 -: 8]);
      hkey   <= hkey << 8;
    end
    if (cmd.shift_start) begin
      pend_idx <= pend_idx;
    end else if (step && more) begin
      pend_idx <= idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt <= '0;
      idx  <= '0;
      pend <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        fill[b] <= '0;
      end
    end else begin
      if (cmd.load) begin
        hcnt <= '0;
      end else if (cmd.hash_step) begin
        hcnt <= hcnt + HCNT_W'(1);
      end

      if (cmd.scan_start) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.shift_start) begin
        // start the move-down just past the matching slot
        idx  <= FILL_W'(pend_idx) + FILL_W'(1);
        pend <= 1'b0;
      end else if (step) begin
        pend <= more;
        if (more) begin
          idx <= idx + FILL_W'(1);
        end
      end

      if (cmd.fill_inc) begin
        fill[bucket] <= fill_cur + FILL_W'(1);
      end else if (cmd.fill_dec) begin
        fill[bucket] <= fill_cur - FILL_W'(1);
      end
    end
  end

  `CHS_ASSERT(a_fill_bound, fill_cur <= FILL_W'(BUCKET_DEPTH), "bucket fill beyond depth")
  `CHS_NEVER(a_ins_full, cmd.ins_write && stat.full, "insert into a full bucket")
  `CHS_NEVER(a_dec_empty, cmd.fill_dec && fill_cur == '0, "delete from an empty bucket")

endmodule

>>> design/chs_ctrl.sv
`include "chained_hash_set_assert.svh"

module chs_ctrl
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     found,
  output status_t  status,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {IDLE, HASH, SCAN, INSERT, SHIFT, RESP} state_t;

  state_t  state;
  logic    r_found;
  status_t r_status;
  logic    absent;

  assign in_ready = state == IDLE;
  assign absent   = status == ST_NOT_FOUND || status == ST_FULL;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.load = in_valid;
      end
      HASH: begin
        cmd.hash_step  = 1'b1;
        cmd.scan_start = stat.hash_last;
      end
      SCAN: begin
        cmd.scan_step   = 1'b1;
        cmd.shift_start = stat.hit && stat.cmd == CMD_DELETE;
      end
      INSERT: begin
        cmd.ins_write = 1'b1;
        cmd.fill_inc  = 1'b1;
      end
      SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.fill_dec   = stat.drained;
      end
      RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // load the output register once it is free, else drop the item when taken
      if (state == RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        found     <= r_found;
        status    <= r_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= HASH;
          end
        end
        HASH: begin
          if (stat.hash_last) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (stat.hit || stat.drained) begin
            r_found <= stat.hit;
            state   <= RESP;
            if (stat.cmd == CMD_INSERT) begin
              if (stat.hit) begin
                r_status <= ST_PRESENT;
              end else if (stat.full) begin
                r_status <= ST_FULL;
              end else begin
                state <= INSERT;
              end
            end else if (stat.cmd == CMD_DELETE && stat.hit) begin
              state <= SHIFT;
            end else begin
              r_status <= stat.hit ? ST_DONE : ST_NOT_FOUND;
            end
          end
        end
        INSERT: begin
          r_status <= ST_DONE;
          state    <= RESP;
        end
        SHIFT: begin
          if (stat.drained) begin
            r_status <= ST_DONE;
            state    <= RESP;
          end
        end
        RESP: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `CHS_NEVER(a_found_status, out_valid && found && absent, "found item reports absence")
  `CHS_NEVER(a_absent_status, out_valid && !found && status == ST_PRESENT, "absent item present")
  `CHS_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "second item taken while busy")

endmodule
